// ----- design/ofvs_pkg.sv -----
package ofvs_pkg;

  localparam int NUM_W   = 74;  // |X| * height, 54 + 20 bits
  localparam int DEN_W   = 46;  // 1000 * focal * dt
  localparam int Q_W     = 16;  // quotient bits kept by each divider lane
  localparam int DIV_LAT = Q_W + 1;  // range check stage plus one stage per bit
  localparam int FLOW_SCALE = 62500000;
  localparam int DEV_SCALE  = 62500;
  localparam int CFG_AW  = 5;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FEW_FEAT   = 3'd1,
    ST_NO_TIME    = 3'd2,
    ST_NO_FOCAL   = 3'd3,
    ST_BAD_HEIGHT = 3'd4,
    ST_BAD_SPEED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_MIN_FEAT   = 3'd0,
    REG_MIN_HEIGHT = 3'd1,
    REG_MAX_HEIGHT = 3'd2,
    REG_MAX_SPEED  = 3'd3,
    REG_PIX_NOISE  = 3'd4,
    REG_SIGN_MODE  = 3'd5,
    REG_FOCAL_X    = 3'd6,
    REG_FOCAL_Y    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]         feature_count;
    logic [19:0]        time_step_us;
    logic signed [19:0] flow_u;
    logic signed [19:0] flow_v;
    logic [19:0]        height_mm;
    logic signed [15:0] roll_mrads;
    logic signed [15:0] pitch_mrads;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               valid_res;
    logic signed [15:0] left_speed;
    logic signed [15:0] forward_speed;
    logic [15:0]        speed_deviation;
  } out_beat_t;

  typedef struct packed {
    logic [9:0]  min_feature_count;
    logic [19:0] min_height_mm;
    logic [19:0] max_height_mm;
    logic [14:0] max_speed_mmps;
    logic [15:0] pixel_noise;
    logic [1:0]  rate_sign_mode;
    logic [15:0] focal_x;
    logic [15:0] focal_y;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    neg_u;
    logic    neg_v;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] num_v;
    logic [NUM_W-1:0] num_d;
    logic [DEN_W-1:0] den_u;
    logic [DEN_W-1:0] den_v;
    logic [DEN_W-1:0] den_d;
  } front_t;

endpackage

// ----- design/ofvs_front.sv -----
module ofvs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  ofvs_pkg::in_beat_t in_beat,
  input  ofvs_pkg::cfg_t    cfg,
  output ofvs_pkg::front_t  front
);

  // stage A: checks and first products
  logic                  va_r;
  ofvs_pkg::status_t     sta_r;
  logic signed [46:0]    fla_u_r, fla_v_r;
  logic signed [32:0]    fra_u_r, fra_v_r;
  logic [35:0]           fdta_x_r, fdta_y_r, pnha_r;
  logic [19:0]           dta_r, ha_r;
  ofvs_pkg::status_t     sta_nxt;
  logic signed [32:0]    pr_u, pr_v;

  always_comb begin
    if (in_beat.feature_count < cfg.min_feature_count) begin
      sta_nxt = ofvs_pkg::ST_FEW_FEAT;
    end else if (in_beat.time_step_us == 20'd0) begin
      sta_nxt = ofvs_pkg::ST_NO_TIME;
    end else if (cfg.focal_x == 16'd0 || cfg.focal_y == 16'd0) begin
      sta_nxt = ofvs_pkg::ST_NO_FOCAL;
    end else if (in_beat.height_mm < cfg.min_height_mm ||
                 in_beat.height_mm > cfg.max_height_mm) begin
      sta_nxt = ofvs_pkg::ST_BAD_HEIGHT;
    end else begin
      sta_nxt = ofvs_pkg::ST_OK;
    end
    pr_u = $signed({1'b0, cfg.focal_x}) * 33'(in_beat.roll_mrads);
    pr_v = $signed({1'b0, cfg.focal_y}) * 33'(in_beat.pitch_mrads);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sta_r    <= sta_nxt;
      fla_u_r  <= 47'(in_beat.flow_u) * 47'(ofvs_pkg::FLOW_SCALE);
      fla_v_r  <= 47'(in_beat.flow_v) * 47'(ofvs_pkg::FLOW_SCALE);
      // the rotation term enters with a plus sign when its sign bit is set
      fra_u_r  <= cfg.rate_sign_mode[0] ? pr_u : -pr_u;
      fra_v_r  <= cfg.rate_sign_mode[1] ? pr_v : -pr_v;
      fdta_x_r <= 36'(cfg.focal_x) * 36'(in_beat.time_step_us);
      fdta_y_r <= 36'(cfg.focal_y) * 36'(in_beat.time_step_us);
      pnha_r   <= 36'(cfg.pixel_noise) * 36'(in_beat.height_mm);
      dta_r    <= in_beat.time_step_us;
      ha_r     <= in_beat.height_mm;
    end
  end

  // stage B: rotation flow, divisors, deviation numerator
  logic                     vb_r;
  ofvs_pkg::status_t        stb_r;
  logic signed [46:0]       flb_u_r, flb_v_r;
  logic signed [53:0]       rotb_u_r, rotb_v_r;
  logic [ofvs_pkg::DEN_W-1:0] denb_u_r, denb_v_r, denb_d_r;
  logic [51:0]              numdb_r;
  logic [19:0]              hb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stb_r    <= sta_r;
      flb_u_r  <= fla_u_r;
      flb_v_r  <= fla_v_r;
      rotb_u_r <= 54'(fra_u_r) * $signed({34'd0, dta_r});
      rotb_v_r <= 54'(fra_v_r) * $signed({34'd0, dta_r});
      denb_u_r <= ofvs_pkg::DEN_W'(fdta_x_r) * 46'd1000;
      denb_v_r <= ofvs_pkg::DEN_W'(fdta_y_r) * 46'd1000;
      denb_d_r <= ofvs_pkg::DEN_W'(fdta_x_r);
      numdb_r  <= 52'(pnha_r) * 52'(ofvs_pkg::DEV_SCALE);
      hb_r     <= ha_r;
    end
  end

  // stage C: residual flow
  logic                     vc_r;
  ofvs_pkg::status_t        stc_r;
  logic signed [54:0]       xc_u_r, xc_v_r;
  logic [ofvs_pkg::DEN_W-1:0] denc_u_r, denc_v_r, denc_d_r;
  logic [51:0]              numdc_r;
  logic [19:0]              hc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stc_r    <= stb_r;
      xc_u_r   <= 55'(flb_u_r) + 55'(rotb_u_r);
      xc_v_r   <= 55'(flb_v_r) + 55'(rotb_v_r);
      denc_u_r <= denb_u_r;
      denc_v_r <= denb_v_r;
      denc_d_r <= denb_d_r;
      numdc_r  <= numdb_r;
      hc_r     <= hb_r;
    end
  end

  // stage D: magnitude and sign
  logic                     vd_r;
  ofvs_pkg::status_t        std_r;
  logic [53:0]              magd_u_r, magd_v_r;
  logic                     negd_u_r, negd_v_r;
  logic [ofvs_pkg::DEN_W-1:0] dend_u_r, dend_v_r, dend_d_r;
  logic [51:0]              numdd_r;
  logic [19:0]              hd_r;
  logic signed [54:0]       absd_u, absd_v;

  always_comb begin
    absd_u = xc_u_r[54] ? -xc_u_r : xc_u_r;
    absd_v = xc_v_r[54] ? -xc_v_r : xc_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      std_r    <= stc_r;
      magd_u_r <= absd_u[53:0];
      magd_v_r <= absd_v[53:0];
      negd_u_r <= xc_u_r[54];
      negd_v_r <= xc_v_r[54];
      dend_u_r <= denc_u_r;
      dend_v_r <= denc_v_r;
      dend_d_r <= denc_d_r;
      numdd_r  <= numdc_r;
      hd_r     <= hc_r;
    end
  end

  // stage E: partial products of magnitude times height
  logic                     ve_r;
  ofvs_pkg::status_t        ste_r;
  logic [46:0]              plo_u_r, phi_u_r, plo_v_r, phi_v_r;
  logic                     nege_u_r, nege_v_r;
  logic [ofvs_pkg::DEN_W-1:0] dene_u_r, dene_v_r, dene_d_r;
  logic [51:0]              numde_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ste_r    <= std_r;
      plo_u_r  <= 47'(magd_u_r[26:0]) * 47'(hd_r);
      phi_u_r  <= 47'(magd_u_r[53:27]) * 47'(hd_r);
      plo_v_r  <= 47'(magd_v_r[26:0]) * 47'(hd_r);
      phi_v_r  <= 47'(magd_v_r[53:27]) * 47'(hd_r);
      nege_u_r <= negd_u_r;
      nege_v_r <= negd_v_r;
      dene_u_r <= dend_u_r;
      dene_v_r <= dend_v_r;
      dene_d_r <= dend_d_r;
      numde_r  <= numdd_r;
    end
  end

  // stage F: combine partial products
  ofvs_pkg::front_t front_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.side.valid <= 1'b0;
    end else if (en) begin
      front_r.side.valid <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r.side.status <= ste_r;
      front_r.side.neg_u  <= nege_u_r;
      front_r.side.neg_v  <= nege_v_r;
      front_r.num_u <= ofvs_pkg::NUM_W'(plo_u_r) + {phi_u_r, 27'd0};
      front_r.num_v <= ofvs_pkg::NUM_W'(plo_v_r) + {phi_v_r, 27'd0};
      front_r.num_d <= ofvs_pkg::NUM_W'(numde_r);
      front_r.den_u <= dene_u_r;
      front_r.den_v <= dene_v_r;
      front_r.den_d <= dene_d_r;
    end
  end

  assign front = front_r;

endmodule

// ----- design/ofvs_divider.sv -----
module ofvs_divider (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ofvs_pkg::NUM_W-1:0]   num,
  input  logic [ofvs_pkg::DEN_W-1:0]   den,
  output logic [ofvs_pkg::Q_W-1:0]     quo,
  output logic                         sat
);

  logic [ofvs_pkg::NUM_W-1:0] rem_r [0:ofvs_pkg::DIV_LAT-1];
  logic [ofvs_pkg::DEN_W-1:0] den_r [0:ofvs_pkg::DIV_LAT-1];
  logic [ofvs_pkg::Q_W-1:0]   q_r   [0:ofvs_pkg::DIV_LAT-1];
  logic                       sat_r [0:ofvs_pkg::DIV_LAT-1];

  // range check: the quotient overflows Q_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      sat_r[0] <= num >= (ofvs_pkg::NUM_W'(den) << ofvs_pkg::Q_W);
    end
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar j = 1; j < ofvs_pkg::DIV_LAT; j++) begin : g_step
    localparam int K = ofvs_pkg::Q_W - j;
    logic [ofvs_pkg::NUM_W-1:0] dsh;
    logic                       take;

    always_comb begin
      dsh  = ofvs_pkg::NUM_W'(den_r[j-1]) << K;
      take = rem_r[j-1] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= take ? rem_r[j-1] - dsh : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= q_r[j-1] | (ofvs_pkg::Q_W'(take) << K);
        sat_r[j] <= sat_r[j-1];
      end
    end
  end

  assign quo = q_r[ofvs_pkg::DIV_LAT-1];
  assign sat = sat_r[ofvs_pkg::DIV_LAT-1];

endmodule

// ----- design/ofvs_back.sv -----
module ofvs_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  ofvs_pkg::side_t          side,
  input  logic [ofvs_pkg::Q_W-1:0] q_u,
  input  logic                     sat_u,
  input  logic [ofvs_pkg::Q_W-1:0] q_v,
  input  logic                     sat_v,
  input  logic [ofvs_pkg::Q_W-1:0] q_d,
  input  logic                     sat_d,
  input  logic [14:0]              max_speed,
  output logic                     out_valid,
  output ofvs_pkg::out_beat_t      out_beat
);

  // stage G: signed speeds and saturated deviation
  logic               vg_r, bigg_r;
  ofvs_pkg::status_t  stg_r;
  logic signed [15:0] leftg_r, fwdg_r;
  logic [14:0]        magg_u_r, magg_v_r;
  logic [15:0]        devg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r    <= side.status;
      bigg_r   <= sat_u || q_u[15] || sat_v || q_v[15];
      leftg_r  <= side.neg_u ? -$signed({1'b0, q_u[14:0]}) : $signed({1'b0, q_u[14:0]});
      fwdg_r   <= side.neg_v ? -$signed({1'b0, q_v[14:0]}) : $signed({1'b0, q_v[14:0]});
      magg_u_r <= q_u[14:0];
      magg_v_r <= q_v[14:0];
      devg_r   <= sat_d ? 16'hFFFF : q_d;
    end
  end

  // stage H: squared magnitudes
  logic               vh_r, bigh_r;
  ofvs_pkg::status_t  sth_r;
  logic signed [15:0] lefth_r, fwdh_r;
  logic [29:0]        sqh_u_r, sqh_v_r, sqh_max_r;
  logic [15:0]        devh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else if (en) begin
      vh_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sth_r     <= stg_r;
      bigh_r    <= bigg_r;
      lefth_r   <= leftg_r;
      fwdh_r    <= fwdg_r;
      sqh_u_r   <= 30'(magg_u_r) * 30'(magg_u_r);
      sqh_v_r   <= 30'(magg_v_r) * 30'(magg_v_r);
      sqh_max_r <= 30'(max_speed) * 30'(max_speed);
      devh_r    <= devg_r;
    end
  end

  // output register: final status and zeroing of rejected beats
  logic                out_valid_r;
  ofvs_pkg::out_beat_t out_beat_r, out_nxt;
  logic                fast;

  always_comb begin
    fast    = (31'(sqh_u_r) + 31'(sqh_v_r)) > 31'(sqh_max_r);
    out_nxt = '0;
    if (sth_r != ofvs_pkg::ST_OK) begin
      out_nxt.status = sth_r;
    end else if (bigh_r || fast) begin
      out_nxt.status = ofvs_pkg::ST_BAD_SPEED;
    end else begin
      out_nxt.status          = ofvs_pkg::ST_OK;
      out_nxt.valid_res       = 1'b1;
      out_nxt.left_speed      = lefth_r;
      out_nxt.forward_speed   = fwdh_r;
      out_nxt.speed_deviation = devh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ----- design/optical_flow_velocity_scaler_core.sv -----
// Optical flow velocity scaler.
//
// Input channel (in_valid / in_stall / in_beat) takes one flow sample per
// beat; the result channel (out_valid / out_stall / out_beat) returns exactly
// one result beat per sample, in order. Configuration registers sit on an
// APB-style port at byte address 4*index and must only be written while the
// pipeline is empty.
//
// Throughput: one beat per cycle unless out_stall holds the pipeline. A beat
// passes six front stages (products, residual flow, magnitude, height
// product), a 17-stage restoring divider (range check plus one quotient bit
// per stage) and three back stages (sign, squares, output reg) to out_valid.
//
// Stall: the whole pipeline advances as one; when the output beat is held
// by out_stall, every stage holds and in_stall is raised, so nothing is lost
// or repeated. Bubbles travel as cleared valid bits.
//
// Reset (rst_n low, synchronous): all valid bits clear and the registers
// return to their default values; the datapath needs no reset.
module optical_flow_velocity_scaler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ofvs_pkg::in_beat_t            in_beat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ofvs_pkg::out_beat_t           out_beat,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ofvs_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ofvs_pkg::cfg_t     cfg_r;
  ofvs_pkg::reg_idx_t cfg_idx;
  logic               en;

  assign cfg_idx = ofvs_pkg::reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;

  // register write: masked to each field's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_feature_count <= 10'd8;
      cfg_r.min_height_mm     <= 20'd100;
      cfg_r.max_height_mm     <= 20'd20000;
      cfg_r.max_speed_mmps    <= 15'd10000;
      cfg_r.pixel_noise       <= 16'd256;
      cfg_r.rate_sign_mode    <= 2'd0;
      cfg_r.focal_x           <= 16'd0;
      cfg_r.focal_y           <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        ofvs_pkg::REG_MIN_FEAT:   cfg_r.min_feature_count <= pwdata[9:0];
        ofvs_pkg::REG_MIN_HEIGHT: cfg_r.min_height_mm     <= pwdata[19:0];
        ofvs_pkg::REG_MAX_HEIGHT: cfg_r.max_height_mm     <= pwdata[19:0];
        ofvs_pkg::REG_MAX_SPEED:  cfg_r.max_speed_mmps    <= pwdata[14:0];
        ofvs_pkg::REG_PIX_NOISE:  cfg_r.pixel_noise       <= pwdata[15:0];
        ofvs_pkg::REG_SIGN_MODE:  cfg_r.rate_sign_mode    <= pwdata[1:0];
        ofvs_pkg::REG_FOCAL_X:    cfg_r.focal_x           <= pwdata[15:0];
        ofvs_pkg::REG_FOCAL_Y:    cfg_r.focal_y           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ofvs_pkg::REG_MIN_FEAT:   prdata = 32'(cfg_r.min_feature_count);
      ofvs_pkg::REG_MIN_HEIGHT: prdata = 32'(cfg_r.min_height_mm);
      ofvs_pkg::REG_MAX_HEIGHT: prdata = 32'(cfg_r.max_height_mm);
      ofvs_pkg::REG_MAX_SPEED:  prdata = 32'(cfg_r.max_speed_mmps);
      ofvs_pkg::REG_PIX_NOISE:  prdata = 32'(cfg_r.pixel_noise);
      ofvs_pkg::REG_SIGN_MODE:  prdata = 32'(cfg_r.rate_sign_mode);
      ofvs_pkg::REG_FOCAL_X:    prdata = 32'(cfg_r.focal_x);
      ofvs_pkg::REG_FOCAL_Y:    prdata = 32'(cfg_r.focal_y);
      default:                  prdata = 32'd0;
    endcase
  end

  // advance everything unless a finished beat is held at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ofvs_pkg::front_t front;

  ofvs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .in_beat (in_beat),
    .cfg     (cfg_r),
    .front   (front)
  );

  logic [ofvs_pkg::Q_W-1:0] q_u, q_v, q_d;
  logic                     sat_u, sat_v, sat_d;

  // three lanes: left speed, forward speed, deviation
  ofvs_divider u_div_u (
    .clk(clk), .en(en), .num(front.num_u), .den(front.den_u), .quo(q_u), .sat(sat_u)
  );
  ofvs_divider u_div_v (
    .clk(clk), .en(en), .num(front.num_v), .den(front.den_v), .quo(q_v), .sat(sat_v)
  );
  ofvs_divider u_div_d (
    .clk(clk), .en(en), .num(front.num_d), .den(front.den_d), .quo(q_d), .sat(sat_d)
  );

  // carry status and signs alongside the divider stages
  ofvs_pkg::side_t side_r [0:ofvs_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ofvs_pkg::DIV_LAT; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= front.side;
      for (int i = 1; i < ofvs_pkg::DIV_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  ofvs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .side     (side_r[ofvs_pkg::DIV_LAT-1]),
    .q_u      (q_u),
    .sat_u    (sat_u),
    .q_v      (q_v),
    .sat_v    (sat_v),
    .q_d      (q_d),
    .sat_d    (sat_d),
    .max_speed(cfg_r.max_speed_mmps),
    .out_valid(out_valid),
    .out_beat (out_beat)
  );

  a_valid_res_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.valid_res |-> out_beat.status == ofvs_pkg::ST_OK)
    else $error("valid_res set with a failing status");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status != ofvs_pkg::ST_OK |->
      out_beat.left_speed == 16'sd0 && out_beat.forward_speed == 16'sd0 &&
      out_beat.speed_deviation == 16'd0 && !out_beat.valid_res)
    else $error("rejected beat carries nonzero outputs");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule
